### hw/rtl/bsr_pkg.sv
// Package for the bitstream reader with start code search.
// Holds store size, derived widths and the operation codes.
// No dependencies.
`default_nettype none

package bsr_pkg;

   localparam int BUFFER_BYTES = 4096;
   localparam int ADDR_W = $clog2(BUFFER_BYTES);
   localparam int IDX_W = ADDR_W + 1;
   localparam logic [16:0] POS_LIMIT = 17'(BUFFER_BYTES * 8);

   typedef enum logic [2:0] {
      OP_WRITE  = 3'd0,
      OP_PEEK   = 3'd1,
      OP_READ   = 3'd2,
      OP_SKIP   = 3'd3,
      OP_REWIND = 3'd4,
      OP_FIND   = 3'd5,
      OP_FINDAT = 3'd6,
      OP_SETPOS = 3'd7
   } op_type;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;

endpackage

`default_nettype wire

### hw/rtl/bsr_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module bsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

### hw/rtl/bitstream_reader_start_code.sv
// Top level of the bitstream reader with start code search.
// Depends on bsr_pkg and bsr_ram.
//
// Usage: pulse start with req_* while busy is low; the item is taken at that
// edge and busy rises. Exactly one result follows, shown on rsp_* for one
// cycle with rsp_valid high; busy falls in that same cycle.
// Ops: write byte, peek, read, skip, rewind, find start code (any or given),
// set position. Bytes are held in one RAM of BUFFER_BYTES entries with
// one read and one write per cycle and a registered read.
// Each RAM byte fetch is a read followed by a wait state (S_FETCH, S_WAIT).
// Skip, rewind, set and write into a free store go straight to the prefix
// check; peek and read first fetch five bytes; find compares byte positions
// one at a time. A write into a full store that keeps bytes first moves each
// kept byte to the front of the store (S_MV_RD, S_MV_WR).
// The prefix check at the end reads three bytes, skipped at end of data.
// Reset clears fill count, position and the state machine; RAM contents
// are undefined until written. The receiver cannot stall: each result is
// taken in its strobe cycle.
`default_nettype none

module bitstream_reader_start_code
   import bsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_op,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [5:0]  req_bit_count,
   input  wire logic [15:0] req_distance,
   input  wire logic [7:0]  req_target_code,
   output logic             rsp_valid,
   output logic [31:0]      rsp_value,
   output logic             rsp_found,
   output logic [7:0]       rsp_start_code,
   output logic [15:0]      rsp_position,
   output logic [15:0]      rsp_bits_available,
   output logic             rsp_at_start_code,
   output logic             rsp_flushed
);

   typedef enum logic [2:0] {S_IDLE, S_FETCH, S_WAIT, S_MV_RD, S_MV_WR} state_type;
   typedef enum logic [1:0] {JOB_PEEK, JOB_SCAN, JOB_CHK} job_type;

   state_type state_ff, state_in;
   job_type job_ff, job_in;
   op_type op_ff, op_in;
   logic [7:0] data_ff, data_in, target_ff, target_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] fill_ff, fill_in, base_ff, base_in, bp_ff, bp_in, k_ff, k_in;
   logic [15:0] pos_ff, pos_in;
   logic [2:0] wcnt_ff, wcnt_in, need_ff, need_in;
   logic [39:0] sr_ff, sr_in;
   logic rd_ok_ff, rd_ok_in;
   logic [31:0] value_ff, value_in;
   logic found_ff, found_in, at_ff, at_in, flushed_ff, flushed_in, valid_ff, valid_in;
   logic [7:0] code_ff, code_in;

   logic ram_we;
   logic [ADDR_W-1:0] ram_wa, ram_ra;
   logic [7:0] ram_wd, ram_q;

   bsr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_wa),
      .wdata (ram_wd),
      .raddr (ram_ra),
      .rdata (ram_q)
   );

   function automatic logic [IDX_W-1:0] chk_base(input logic [15:0] p);
      logic [16:0] s;
      s = {1'b0, p} + 17'd7;
      return s[IDX_W+2:3];
   endfunction

   function automatic logic [15:0] sat_pos(input logic [16:0] s);
      return (s > POS_LIMIT) ? POS_LIMIT[15:0] : s[15:0];
   endfunction

   logic [IDX_W-1:0] fa, bp, len, mv_ra;
   logic [39:0] sh;
   logic [31:0] peek_val;
   logic [15:0] newpos;
   logic [15:0] fill_bits;

   always_comb begin
      fa = base_ff + IDX_W'(wcnt_ff);
      bp = pos_ff[IDX_W+2:3];
      len = fill_ff - bp_ff;
      mv_ra = bp_ff + k_ff;
      sh = sr_ff << pos_ff[2:0];
      peek_val = sh[39:8] >> (6'd32 - cnt_ff);
      newpos = pos_ff;

      state_in = state_ff; job_in = job_ff; op_in = op_ff;
      data_in = data_ff; target_in = target_ff; cnt_in = cnt_ff;
      fill_in = fill_ff; base_in = base_ff; bp_in = bp_ff; k_in = k_ff;
      pos_in = pos_ff; wcnt_in = wcnt_ff; need_in = need_ff; sr_in = sr_ff;
      rd_ok_in = rd_ok_ff; value_in = value_ff; found_in = found_ff;
      at_in = at_ff; flushed_in = flushed_ff; code_in = code_ff;
      valid_in = 1'b0;
      ram_we = 1'b0;
      ram_wa = fill_ff[ADDR_W-1:0];
      ram_wd = data_ff;
      ram_ra = fa[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = op_type'(req_op);
               data_in = req_data_byte;
               target_in = req_target_code;
               cnt_in = (req_bit_count > 6'd32) ? 6'd32 : req_bit_count;
               value_in = '0; found_in = 1'b0; code_in = '0; flushed_in = 1'b0;
               at_in = 1'b0;
               wcnt_in = '0;
               state_in = S_FETCH;
               job_in = JOB_CHK;
               need_in = 3'd3;
               case (op_type'(req_op))
                  OP_WRITE: begin
                     ram_wd = req_data_byte;
                     if (fill_ff < IDX_W'(BUFFER_BYTES)) begin
                        ram_we = 1'b1;
                        fill_in = fill_ff + 1'b1;
                        base_in = chk_base(pos_ff);
                     end else if (bp >= fill_ff || bp == '0) begin
                        ram_we = 1'b1;
                        ram_wa = '0;
                        fill_in = IDX_W'(1);
                        pos_in = '0;
                        flushed_in = (bp == '0);
                        base_in = '0;
                     end else begin
                        bp_in = bp;
                        k_in = '0;
                        state_in = S_MV_RD;
                     end
                  end
                  OP_PEEK, OP_READ: begin
                     base_in = bp;
                     need_in = 3'd5;
                     job_in = JOB_PEEK;
                  end
                  OP_FIND, OP_FINDAT: begin
                     base_in = chk_base(pos_ff);
                     need_in = 3'd4;
                     job_in = JOB_SCAN;
                  end
                  OP_SKIP: begin
                     newpos = sat_pos({1'b0, pos_ff} + {1'b0, req_distance});
                     pos_in = newpos;
                     base_in = chk_base(newpos);
                  end
                  OP_REWIND: begin
                     newpos = (req_distance > pos_ff) ? 16'd0 : pos_ff - req_distance;
                     pos_in = newpos;
                     base_in = chk_base(newpos);
                  end
                  default: begin
                     newpos = sat_pos({1'b0, req_distance});
                     pos_in = newpos;
                     base_in = chk_base(newpos);
                  end
               endcase
            end
         end
         S_FETCH: begin
            if (job_ff == JOB_SCAN && base_ff >= fill_ff) begin
               newpos = {fill_ff, 3'b000};
               pos_in = newpos;
               base_in = chk_base(newpos);
               job_in = JOB_CHK; need_in = 3'd3; wcnt_in = '0;
            end else if (job_ff == JOB_CHK && base_ff >= fill_ff) begin
               at_in = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else if (wcnt_ff < need_ff) begin
               rd_ok_in = (fa < fill_ff);
               state_in = S_WAIT;
            end else begin
               case (job_ff)
                  JOB_PEEK: begin
                     value_in = peek_val;
                     if (op_ff == OP_READ) begin
                        newpos = sat_pos({1'b0, pos_ff} + 17'(cnt_ff));
                     end
                     pos_in = newpos;
                     base_in = chk_base(newpos);
                     job_in = JOB_CHK; need_in = 3'd3; wcnt_in = '0;
                  end
                  JOB_SCAN: begin
                     if (sr_ff[31:24] == BYTE_ZERO && sr_ff[23:16] == BYTE_ZERO &&
                         sr_ff[15:8] == BYTE_ONE) begin
                        newpos = {base_ff + IDX_W'(4), 3'b000};
                        pos_in = newpos;
                        if (op_ff == OP_FIND || sr_ff[7:0] == target_ff) begin
                           found_in = 1'b1;
                           code_in = sr_ff[7:0];
                           base_in = chk_base(newpos);
                           job_in = JOB_CHK; need_in = 3'd3; wcnt_in = '0;
                        end else begin
                           base_in = base_ff + IDX_W'(4);
                           wcnt_in = '0;
                        end
                     end else begin
                        base_in = base_ff + 1'b1;
                        wcnt_in = 3'd3;
                     end
                  end
                  default: begin
                     at_in = (sr_ff[23:16] == BYTE_ZERO && sr_ff[15:8] == BYTE_ZERO &&
                              sr_ff[7:0] == BYTE_ONE);
                     valid_in = 1'b1;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WAIT: begin
            sr_in = {sr_ff[31:0], rd_ok_ff ? ram_q : BYTE_ZERO};
            wcnt_in = wcnt_ff + 1'b1;
            state_in = S_FETCH;
         end
         S_MV_RD: begin
            if (k_ff == len) begin
               ram_we = 1'b1;
               ram_wa = len[ADDR_W-1:0];
               fill_in = len + 1'b1;
               newpos = pos_ff - {bp_ff, 3'b000};
               pos_in = newpos;
               base_in = chk_base(newpos);
               job_in = JOB_CHK; need_in = 3'd3; wcnt_in = '0;
               state_in = S_FETCH;
            end else begin
               ram_ra = mv_ra[ADDR_W-1:0];
               state_in = S_MV_WR;
            end
         end
         S_MV_WR: begin
            ram_we = 1'b1;
            ram_wa = k_ff[ADDR_W-1:0];
            ram_wd = ram_q;
            k_in = k_ff + 1'b1;
            state_in = S_MV_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         pos_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         pos_ff <= pos_in;
         valid_ff <= valid_in;
      end
      job_ff <= job_in; op_ff <= op_in; data_ff <= data_in; target_ff <= target_in;
      cnt_ff <= cnt_in; base_ff <= base_in; bp_ff <= bp_in; k_ff <= k_in;
      wcnt_ff <= wcnt_in; need_ff <= need_in; sr_ff <= sr_in; rd_ok_ff <= rd_ok_in;
      value_ff <= value_in; found_ff <= found_in; at_ff <= at_in;
      flushed_ff <= flushed_in; code_ff <= code_in;
   end

   always_comb begin
      fill_bits = {fill_ff, 3'b000};
      rsp_bits_available = (fill_bits > pos_ff) ? fill_bits - pos_ff : 16'd0;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;
   assign rsp_found = found_ff;
   assign rsp_start_code = code_ff;
   assign rsp_position = pos_ff;
   assign rsp_at_start_code = at_ff;
   assign rsp_flushed = flushed_ff;

endmodule

`default_nettype wire
